### design/i2cbm_pkg.sv
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Command kinds carried on the input channel
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_ACK   = 3'd4;
  localparam logic [2:0] KIND_NACK  = 3'd5;
  localparam logic [2:0] KIND_CHECK = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_FULL_WAIT   = 2'd0;
  localparam logic [1:0] REG_SETUP_WAIT  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_WAIT = 2'd2;

  // Phase step within a command
  typedef logic [3:0] phase_t;
  localparam phase_t PHASE_0    = 4'd0;
  localparam phase_t PHASE_1    = 4'd1;
  localparam phase_t PHASE_2    = 4'd2;
  localparam phase_t PHASE_3    = 4'd3;
  localparam phase_t PHASE_4    = 4'd4;
  localparam phase_t PHASE_IDLE = 4'd15;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned WAIT_WIDTH      = 16;
  localparam int unsigned BYTE_WIDTH      = 8;

  localparam logic [WAIT_WIDTH-1:0] FULL_WAIT_RST   = 16'd500;
  localparam logic [WAIT_WIDTH-1:0] SETUP_WAIT_RST  = 16'd166;
  localparam logic [WAIT_WIDTH-1:0] SAMPLE_WAIT_RST = 16'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

### design/i2c_bit_level_master_core.sv
`timescale 1ns / 1ps

// Bit-level I2C master. Every input transfer is one tick of the bus timer: it
// carries an optional command (start, stop, write byte, read byte, ack, nack,
// check ack) and the sampled SDA level, and every tick yields exactly one
// result transfer with the SCL/SDA/enable levels after that tick, busy, a
// one-tick done pulse, the last byte read and the last acknowledge seen.
// A command is taken only while idle; the block walks its pin phases, each
// held for full_wait, setup_wait or sample_wait ticks (a zero register counts
// as one). The phase step and countdown sit in a single combinational pass
// ahead of the result register, so a new transfer is accepted every cycle
// unless the result register is full and stalled.
module i2c_bit_level_master_core
  import i2cbm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [WAIT_WIDTH-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd_valid,
  input  logic [2:0]            in_kind,
  input  logic [BYTE_WIDTH-1:0] in_write_data,
  input  logic                  in_sda_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl,
  output logic                  out_sda_out,
  output logic                  out_sda_enable,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [BYTE_WIDTH-1:0] out_read_data,
  output logic                  out_ack_seen
);

  localparam int unsigned CW = COUNT_WIDTH;

  // Configuration registers
  logic [WAIT_WIDTH-1:0] full_wait_r, setup_wait_r, sample_wait_r;

  // Bus state
  phase_t                phase_r, phase_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic [3:0]            bit_left_r, bit_left_nxt;
  logic [CW-1:0]         wait_left_r, wait_left_nxt;
  logic [BYTE_WIDTH-1:0] shift_r, shift_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  drv_r, drv_nxt;
  logic [BYTE_WIDTH-1:0] last_read_r, last_read_nxt;
  logic                  last_ack_r, last_ack_nxt;
  logic                  done_nxt;

  // Result register
  logic                  out_valid_r;
  logic                  out_scl_r, out_sda_r, out_drv_r, out_busy_r, out_done_r;
  logic [BYTE_WIDTH-1:0] out_read_r;
  logic                  out_ack_r;

  logic in_acc;
  logic start;
  logic run;
  logic fin;
  logic [2:0]            cmd_e;
  phase_t                p_e;
  logic [BYTE_WIDTH-1:0] sb_e;
  logic [3:0]            bl_e;
  logic [CW-1:0]         w;
  logic [CW+WAIT_WIDTH-1:0] full_ext, setup_ext, sample_ext;
  logic [CW-1:0]         full_c, setup_c, sample_c;

  // Hold off input only while a result waits and is stalled
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Fit the wait registers to the counter, zero standing for one tick
  always_comb begin
    full_ext   = {{CW{1'b0}}, full_wait_r};
    setup_ext  = {{CW{1'b0}}, setup_wait_r};
    sample_ext = {{CW{1'b0}}, sample_wait_r};
    full_c   = (full_ext[CW-1:0] == '0) ? CW'(1) : full_ext[CW-1:0];
    setup_c  = (setup_ext[CW-1:0] == '0) ? CW'(1) : setup_ext[CW-1:0];
    sample_c = (sample_ext[CW-1:0] == '0) ? CW'(1) : sample_ext[CW-1:0];
  end

  // Step the phase sequence by one tick
  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    bit_left_nxt  = bit_left_r;
    wait_left_nxt = wait_left_r;
    shift_nxt     = shift_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    drv_nxt       = drv_r;
    last_read_nxt = last_read_r;
    last_ack_nxt  = last_ack_r;
    done_nxt      = 1'b0;
    w             = full_c;
    fin           = 1'b0;

    start = (phase_r == PHASE_IDLE) && in_cmd_valid &&
            (in_kind inside {[KIND_START:KIND_CHECK]});
    run   = start || ((phase_r != PHASE_IDLE) && (wait_left_r <= CW'(1)));

    cmd_e = start ? in_kind : cmd_r;
    p_e   = start ? PHASE_0 : phase_r;
    sb_e  = start ? ((in_kind == KIND_WRITE) ? in_write_data : '0) : shift_r;
    bl_e  = start ? BITS_PER_BYTE : bit_left_r;

    if (run) begin
      cmd_nxt      = cmd_e;
      shift_nxt    = sb_e;
      bit_left_nxt = bl_e;
      phase_nxt    = p_e + 4'd1;
      case (cmd_e)
        KIND_START: begin
          case (p_e)
            PHASE_0: begin scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; end
            PHASE_1: sda_nxt = 1'b0;
            PHASE_2: begin scl_nxt = 1'b0; w = setup_c; end
            default: fin = 1'b1;
          endcase
        end
        KIND_STOP: begin
          case (p_e)
            PHASE_0: begin sda_nxt = 1'b0; scl_nxt = 1'b1; drv_nxt = 1'b1; end
            PHASE_1: sda_nxt = 1'b1;
            default: fin = 1'b1;
          endcase
        end
        KIND_WRITE: begin
          case (p_e)
            PHASE_0: begin scl_nxt = 1'b0; drv_nxt = 1'b1; w = setup_c; end
            PHASE_1: begin
              sda_nxt   = sb_e[BYTE_WIDTH-1];
              shift_nxt = {sb_e[BYTE_WIDTH-2:0], 1'b0};
            end
            PHASE_2: begin
              scl_nxt      = 1'b1;
              bit_left_nxt = bl_e - 4'd1;
              phase_nxt    = (bl_e != 4'd1) ? PHASE_0 : PHASE_3;
            end
            PHASE_3: begin scl_nxt = 1'b0; w = setup_c; end
            default: fin = 1'b1;
          endcase
        end
        KIND_READ: begin
          case (p_e)
            PHASE_0: begin sda_nxt = 1'b1; drv_nxt = 1'b0; scl_nxt = 1'b0; end
            PHASE_1: begin scl_nxt = 1'b1; w = sample_c; end
            PHASE_2: begin
              shift_nxt    = {sb_e[BYTE_WIDTH-2:0], in_sda_in};
              bit_left_nxt = bl_e - 4'd1;
              phase_nxt    = (bl_e != 4'd1) ? PHASE_0 : PHASE_3;
            end
            default: begin
              scl_nxt       = 1'b0;
              last_read_nxt = sb_e;
              fin           = 1'b1;
            end
          endcase
        end
        KIND_ACK, KIND_NACK: begin
          case (p_e)
            PHASE_0: begin drv_nxt = 1'b1; scl_nxt = 1'b0; end
            PHASE_1: sda_nxt = (cmd_e == KIND_NACK);
            PHASE_2: scl_nxt = 1'b1;
            PHASE_3: scl_nxt = 1'b0;
            default: begin drv_nxt = 1'b0; fin = 1'b1; end
          endcase
        end
        KIND_CHECK: begin
          case (p_e)
            PHASE_0: scl_nxt = 1'b0;
            PHASE_1: sda_nxt = 1'b1;
            PHASE_2: begin drv_nxt = 1'b0; scl_nxt = 1'b1; end
            default: begin
              last_ack_nxt = !in_sda_in;
              scl_nxt      = 1'b0;
              drv_nxt      = !in_sda_in;
              fin          = 1'b1;
            end
          endcase
        end
        default: fin = 1'b1;
      endcase

      if (fin) begin
        phase_nxt     = PHASE_IDLE;
        done_nxt      = 1'b1;
        wait_left_nxt = '0;
      end else begin
        wait_left_nxt = w;
      end
    end else if (phase_r != PHASE_IDLE) begin
      // count the current phase down
      wait_left_nxt = wait_left_r - CW'(1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_wait_r   <= FULL_WAIT_RST;
      setup_wait_r  <= SETUP_WAIT_RST;
      sample_wait_r <= SAMPLE_WAIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FULL_WAIT:   full_wait_r   <= cfg_data;
        REG_SETUP_WAIT:  setup_wait_r  <= cfg_data;
        REG_SAMPLE_WAIT: sample_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance bus state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_IDLE;
      cmd_r       <= KIND_START;
      bit_left_r  <= '0;
      wait_left_r <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      last_read_r <= '0;
      last_ack_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      bit_left_r  <= bit_left_nxt;
      wait_left_r <= wait_left_nxt;
      shift_r     <= shift_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      drv_r       <= drv_nxt;
      last_read_r <= last_read_nxt;
      last_ack_r  <= last_ack_nxt;
    end
  end

  // Result register: fill on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_drv_r  <= drv_nxt;
      out_busy_r <= (phase_nxt != PHASE_IDLE);
      out_done_r <= done_nxt;
      out_read_r <= last_read_nxt;
      out_ack_r  <= last_ack_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl        = out_scl_r;
  assign out_sda_out    = out_sda_r;
  assign out_sda_enable = out_drv_r;
  assign out_busy_res   = out_busy_r;
  assign out_done_res   = out_done_r;
  assign out_read_data  = out_read_r;
  assign out_ack_seen   = out_ack_r;

  // A finishing tick never reports busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_busy_r)
    else $error("done reported while busy");

  // Only the used phase steps or idle are ever held
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= PHASE_4) || (phase_r == PHASE_IDLE))
    else $error("phase out of range");

  // Bit counter never exceeds one byte
  assert property (@(posedge clk) disable iff (!rst_n)
    bit_left_r <= BITS_PER_BYTE)
    else $error("bit counter out of range");

  // A running phase with time left counts down by one per accepted tick
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_r != PHASE_IDLE) && (wait_left_r > CW'(1))) |=>
      (wait_left_r == $past(wait_left_r) - CW'(1)))
    else $error("wait countdown slipped");

endmodule
